[hdl/hpq_pkg.sv]
// shared types and constants for the max-heap priority queue
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    CMD_PUSH   = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

endpackage

[hdl/hpq_ram.sv]
// heap store: one write port, two registered read ports
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

[hdl/hpq_ctrl.sv]
// heap sequencer: push, delete, sift down and sift up over the heap store
`timescale 1ns / 1ps

module hpq_ctrl #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hpq_pkg::cmd_e                 in_cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] in_value_i,
  input  logic [AW-1:0]                 in_index_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output hpq_pkg::status_e              res_status_o,
  output logic signed [VALUE_WIDTH-1:0] res_top_o,
  output logic [CW-1:0]                 res_count_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [VALUE_WIDTH-1:0]        mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_a_o,
  output logic [AW-1:0]                 mem_raddr_b_o,
  input  logic signed [VALUE_WIDTH-1:0] mem_rdata_a_i,
  input  logic signed [VALUE_WIDTH-1:0] mem_rdata_b_i
);

  import hpq_pkg::*;

  localparam int unsigned XW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DOWN = 6'b000100,
    S_UP   = 6'b001000,
    S_WRB  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  status_e                       status_q, status_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic signed [VALUE_WIDTH-1:0] top_q;

  logic [XW-1:0]                 left_x, right_x, kid_l_x, kid_r_x;
  logic [AW-1:0]                 left_a, right_a, down_pos, kid_base;
  logic [AW-1:0]                 par_pos, gpar_pos, push_pos, push_par, last_a;
  logic [CW-1:0]                 last_cnt;
  logic                          l_ok, r_ok, take_l, take_r;
  logic signed [VALUE_WIDTH-1:0] bigger;

  // child positions of the current slot
  assign left_x  = XW'({pos_q, 1'b1});
  assign right_x = left_x + XW'(1);
  assign left_a  = left_x[AW-1:0];
  assign right_a = right_x[AW-1:0];
  assign l_ok    = left_x < XW'(cnt_q);
  assign r_ok    = right_x < XW'(cnt_q);
  assign take_l  = l_ok && (val_q < mem_rdata_a_i);
  assign bigger  = take_l ? mem_rdata_a_i : val_q;
  assign take_r  = r_ok && (bigger < mem_rdata_b_i);
  assign down_pos = take_r ? right_a : (take_l ? left_a : pos_q);

  // children to read for the next level down
  assign kid_base = (state_q == S_DOWN) ? down_pos : pos_q;
  assign kid_l_x  = XW'({kid_base, 1'b1});
  assign kid_r_x  = kid_l_x + XW'(1);

  // parent positions
  assign par_pos  = AW'((pos_q - AW'(1)) >> 1);
  assign gpar_pos = AW'((par_pos - AW'(1)) >> 1);
  assign push_pos = cnt_q[AW-1:0];
  assign push_par = AW'((push_pos - AW'(1)) >> 1);
  assign last_cnt = cnt_q - CW'(1);
  assign last_a   = last_cnt[AW-1:0];

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    val_d         = val_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = val_q;
    mem_raddr_a_o = kid_l_x[AW-1:0];
    mem_raddr_b_o = kid_r_x[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          if (in_cmd_i == CMD_PUSH) begin
            if (cnt_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              val_d = in_value_i;
              pos_d = push_pos;
              cnt_d = cnt_q + CW'(1);
              if (cnt_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = in_value_i;
                state_d     = S_DONE;
              end else begin
                mem_raddr_a_o = push_par;
                state_d       = S_UP;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else if (CW'(in_index_i) >= cnt_q) begin
              status_d = ST_BADIDX;
              state_d  = S_DONE;
            end else begin
              cnt_d = last_cnt;
              pos_d = in_index_i;
              if (CW'(in_index_i) == last_cnt) begin
                state_d = S_DONE;
              end else begin
                mem_raddr_a_o = last_a;
                state_d       = S_LOAD;
              end
            end
          end
        end
      end
      S_LOAD: begin
        val_d   = mem_rdata_a_i;
        state_d = S_DOWN;
      end
      S_DOWN: begin
        if (take_l || take_r) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = take_r ? mem_rdata_b_i : mem_rdata_a_i;
          pos_d       = down_pos;
        end else if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_DONE;
        end else begin
          mem_raddr_a_o = par_pos;
          state_d       = S_UP;
        end
      end
      S_UP: begin
        mem_we_o = 1'b1;
        if (val_q > mem_rdata_a_i) begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = par_pos;
          if (par_pos == '0) begin
            state_d = S_WRB;
          end else begin
            mem_raddr_a_o = gpar_pos;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_WRB: begin
        mem_we_o = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    // copy of slot zero
    if (mem_we_o && (mem_waddr_o == '0)) begin
      top_q <= mem_wdata_o;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_status_o = status_q;
  assign res_count_o  = cnt_q;
  assign res_top_o    = (cnt_q == '0) ? '0 : top_q;

endmodule

[hdl/max_heap_priority_queue_unit.sv]
// top level of the max-heap priority queue with stream ports
`timescale 1ns / 1ps

// one request on the slave stream: tuser is the command (push or delete),
// tdata carries the value to push and the slot index to delete.
// one response per request on the master stream: status, the largest entry
// (zero when empty), the entry count and an empty flag.
// the heap lives in a dual-read, single-write ram with registered reads;
// each tree level is read, compared and written in an S_DOWN or S_UP step.
// a push into an empty heap writes slot zero directly; other pushes sift
// up. a delete moves the last entry into the freed slot, sifts it down and
// then, unless it sits at the root, up; refused requests and a delete of
// the last slot leave the ram untouched.
// one request is worked on at a time; the response sits in an output
// register so a new request is taken while it waits for tready.
// if the response register is still full when the next result is done,
// the sequencer holds until tready frees it.
// reset empties the heap at once: no clearing pass, the ram is not touched.

module max_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned AW         = $clog2(CAPACITY),
  localparam int unsigned CW         = $clog2(CAPACITY + 1),
  localparam int unsigned IN_BITS    = VALUE_WIDTH + AW,
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = 2 + VALUE_WIDTH + CW + 1,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // value, index
  input  logic             s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // status, top_value, entry_count, is_empty
);

  import hpq_pkg::*;

  logic                          res_valid, res_ready;
  status_e                       res_status;
  logic signed [VALUE_WIDTH-1:0] res_top;
  logic [CW-1:0]                 res_count;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [VALUE_WIDTH-1:0]        mem_wdata, mem_rdata_a, mem_rdata_b;

  logic                          out_valid_q;
  status_e                       out_status_q;
  logic [VALUE_WIDTH-1:0]        out_top_q;
  logic [CW-1:0]                 out_count_q;

  hpq_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_value_i   (s_axis_tdata[VALUE_WIDTH-1:0]),
    .in_index_i   (s_axis_tdata[IN_BITS-1:VALUE_WIDTH]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_top_o    (res_top),
    .res_count_o  (res_count),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_a_o(mem_raddr_a),
    .mem_raddr_b_o(mem_raddr_b),
    .mem_rdata_a_i(mem_rdata_a),
    .mem_rdata_b_i(mem_rdata_b)
  );

  hpq_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW),
    .DW   (VALUE_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_status_q <= res_status;
      out_top_q    <= res_top;
      out_count_q  <= res_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({(out_count_q == '0), out_count_q, out_top_q, out_status_q});

endmodule

[hdl/hpq_checker.sv]
// port-level checks for the max-heap priority queue
`timescale 1ns / 1ps

module hpq_checker #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned CW         = $clog2(CAPACITY + 1),
  localparam int unsigned OUT_W      = ((2 + VALUE_WIDTH + CW + 1 + 7) / 8) * 8,
  localparam int unsigned TOP_LO     = 2,
  localparam int unsigned CNT_LO     = TOP_LO + VALUE_WIDTH,
  localparam int unsigned EMPTY_BIT  = CNT_LO + CW
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic [VALUE_WIDTH-1:0] top_f;
  logic [CW-1:0]          cnt_f;
  logic                   empty_f;

  assign top_f   = m_axis_tdata[CNT_LO-1:TOP_LO];
  assign cnt_f   = m_axis_tdata[EMPTY_BIT-1:CNT_LO];
  assign empty_f = m_axis_tdata[EMPTY_BIT];

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (empty_f == (cnt_f == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && empty_f |-> (top_f == '0))
    else $error("nonzero top on empty heap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt_f <= CW'(CAPACITY)))
    else $error("count beyond capacity");

endmodule

bind max_heap_priority_queue_unit hpq_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_hpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
